FILE: hw/rtl/trd_pkg.sv
package trd_pkg;

  // image kind codes
  localparam logic [1:0] KIND_PALETTE = 2'd0;
  localparam logic [1:0] KIND_TRUE    = 2'd1;
  localparam logic [1:0] KIND_GREY    = 2'd2;

  // palette entry counter width: holds up to 511 entries
  localparam int unsigned ENT_W = 10;

  // effective (already clamped) configuration
  typedef struct packed {
    logic [1:0]       kind;
    logic             rle;
    logic [2:0]       pix_bytes;    // 1..4
    logic [2:0]       entry_bytes;  // 2..4
    logic [7:0]       first;
    logic [ENT_W-1:0] entries;      // min(palette_entries, depth, 511)
  } cfg_t;

  // finished pixel waiting for color decode
  typedef struct packed {
    logic [31:0] pix;
    logic        bad;
    logic [7:0]  rep;
    logic        last;
  } pend_t;

endpackage

FILE: hw/rtl/trd_byte_if.sv
interface trd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

FILE: hw/rtl/trd_pixel_if.sv
interface trd_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_red;
  logic [7:0] chan_green;
  logic [7:0] chan_blue;
  logic [7:0] chan_alpha;
  logic [7:0] repeat_count;
  logic       bad_index;
  logic       last_pixel;

  modport source (
    output valid, output chan_red, output chan_green, output chan_blue,
    output chan_alpha, output repeat_count, output bad_index, output last_pixel,
    input ready
  );
  modport sink (
    input valid, input chan_red, input chan_green, input chan_blue,
    input chan_alpha, input repeat_count, input bad_index, input last_pixel,
    output ready
  );
endinterface

FILE: hw/rtl/trd_ram.sv
module trd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/trd_parser.sv
module trd_parser import trd_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cfg_t                             cfg,
  input  logic                             restart,
  input  logic [31:0]                      restart_total,
  input  logic                             in_valid,
  input  logic [7:0]                       in_data,
  output logic                             in_ready,
  output pend_t                            pend,
  output logic                             pend_valid,
  input  logic                             pend_take,
  output logic [3:0]                       lane_we,
  output logic [$clog2(PALETTE_DEPTH)-1:0] waddr,
  output logic [7:0]                       wdata,
  output logic                             re,
  output logic [$clog2(PALETTE_DEPTH)-1:0] raddr
);

  localparam int AddrW = $clog2(PALETTE_DEPTH);

  logic [ENT_W-1:0] load_entry;
  logic [1:0]       load_lane;
  logic [1:0]       byte_idx;
  logic [31:0]      pix_asm;
  logic             is_run;
  logic [7:0]       packet_left;
  logic [31:0]      pixels_left;

  logic        fire, loading, hdr, pix_byte, done, last, bad, lane_end;
  logic [1:0]  idx_next;
  logic [31:0] asm_next, left_next;
  logic [7:0]  rep_raw, rep;
  logic [32:0] pal_idx;

  always_comb begin
    fire     = in_valid && in_ready;
    loading  = load_entry < cfg.entries;
    hdr      = !loading && cfg.rle && (packet_left == 8'd0);
    pix_byte = fire && !loading && !hdr;
    idx_next = byte_idx + 2'd1;
    asm_next = pix_asm;
    asm_next[{byte_idx, 3'b000} +: 8] = in_data;
    // 4 bytes wraps the index to 0
    done     = pix_byte && (idx_next == cfg.pix_bytes[1:0]);
    rep_raw  = (cfg.rle && is_run) ? packet_left : 8'd1;
    rep      = (pixels_left < {24'd0, rep_raw}) ? pixels_left[7:0] : rep_raw;
    left_next = pixels_left - {24'd0, rep};
    last     = (left_next == 32'd0);
    pal_idx  = {1'b0, asm_next} + {25'd0, cfg.first};
    bad      = (cfg.kind == KIND_PALETTE) &&
               (pal_idx >= {{(33 - ENT_W){1'b0}}, cfg.entries});
    lane_end = (load_lane == (cfg.entry_bytes[1:0] - 2'd1));
  end

  assign in_ready = !pend_valid || pend_take;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane_we[i] = fire && loading && (load_lane == 2'(i));
    end
  end
  assign waddr = AddrW'(load_entry);
  assign wdata = in_data;
  assign re    = done;
  assign raddr = AddrW'(pal_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_entry  <= '0;
      load_lane   <= '0;
      byte_idx    <= '0;
      pix_asm     <= '0;
      is_run      <= 1'b0;
      packet_left <= '0;
      pixels_left <= 32'd1;
      pend_valid  <= 1'b0;
    end else begin
      if (done) begin
        pend_valid <= 1'b1;
      end else if (pend_take) begin
        pend_valid <= 1'b0;
      end

      if (restart) begin
        load_entry  <= '0;
        load_lane   <= '0;
        byte_idx    <= '0;
        pix_asm     <= '0;
        is_run      <= 1'b0;
        packet_left <= '0;
        pixels_left <= restart_total;
      end else if (fire) begin
        if (loading) begin
          if (lane_end) begin
            load_lane  <= '0;
            load_entry <= load_entry + ENT_W'(1);
          end else begin
            load_lane <= load_lane + 2'd1;
          end
        end else if (hdr) begin
          is_run      <= in_data[7];
          packet_left <= {1'b0, in_data[6:0]} + 8'd1;
        end else if (done) begin
          byte_idx <= '0;
          pix_asm  <= '0;
          if (last) begin
            // image complete: start over for the next one
            load_entry  <= '0;
            load_lane   <= '0;
            is_run      <= 1'b0;
            packet_left <= '0;
            pixels_left <= restart_total;
          end else begin
            pixels_left <= left_next;
            if (cfg.rle) begin
              packet_left <= is_run ? 8'd0 : packet_left - 8'd1;
            end
          end
        end else begin
          byte_idx <= idx_next;
          pix_asm  <= asm_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      pend.pix  <= asm_next;
      pend.bad  <= bad;
      pend.rep  <= rep;
      pend.last <= last;
    end
  end

`ifndef SYNTHESIS
  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    pixels_left != 32'd0)
    else $error("pixels_left reached zero without restart");

  a_rep_nonzero: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> pend.rep != 8'd0)
    else $error("pending pixel with zero repeat count");

  a_one_lane: assert property (@(posedge clk) disable iff (rst)
    $onehot0(lane_we) && !(|lane_we && done))
    else $error("palette write overlaps pixel or multiple lanes");

  a_last_reload: assert property (@(posedge clk) disable iff (rst)
    (done && last && !restart) |=> pixels_left == $past(restart_total))
    else $error("pixel count not reloaded after last pixel");
`endif

endmodule

FILE: hw/rtl/trd_out.sv
module trd_out import trd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  pend_t       pend,
  input  logic        pend_valid,
  output logic        pend_take,
  input  logic [31:0] pal_data,
  trd_pixel_if.source pixels
);

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  // little-endian bytes: 5-5-5 for two bytes, B,G,R(,A) for three or four
  function automatic rgba_t unpack(input logic [31:0] d, input logic [2:0] n);
    rgba_t c;
    c = '0;
    if (n == 3'd2) begin
      c.r = {3'b000, d[14:10]};
      c.g = {3'b000, d[9:5]};
      c.b = {3'b000, d[4:0]};
    end else if (n >= 3'd3) begin
      c.r = d[23:16];
      c.g = d[15:8];
      c.b = d[7:0];
      c.a = (n == 3'd4) ? d[31:24] : 8'd0;
    end
    return c;
  endfunction

  logic  o_v;
  rgba_t col;

  assign pend_take = pend_valid && (!o_v || pixels.ready);

  always_comb begin
    col = '0;
    unique case (cfg.kind)
      KIND_PALETTE: begin
        if (!pend.bad) begin
          col = unpack(pal_data, cfg.entry_bytes);
        end
      end
      KIND_GREY: begin
        col.r = pend.pix[7:0];
        col.g = (cfg.pix_bytes >= 3'd2) ? pend.pix[15:8] : 8'd0;
      end
      default: col = unpack(pend.pix, cfg.pix_bytes);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (pend_take) begin
      o_v <= 1'b1;
    end else if (pixels.ready) begin
      o_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_take) begin
      pixels.chan_red     <= col.r;
      pixels.chan_green   <= col.g;
      pixels.chan_blue    <= col.b;
      pixels.chan_alpha   <= col.a;
      pixels.repeat_count <= pend.rep;
      pixels.bad_index    <= pend.bad;
      pixels.last_pixel   <= pend.last;
    end
  end

  assign pixels.valid = o_v;

endmodule

FILE: hw/rtl/tga_rle_pixel_decoder.sv
// TGA pixel-data decoder. Feed the byte stream that follows the TGA header,
// one byte per word on the stream channel; decoded pixels come out on the
// pixels channel, one word per pixel or per RLE run, with a repeat count.
// The stream opens with palette_entries palette entries (written into an
// internal palette RAM), then the pixels, raw or as RLE packets when
// rle_enable is set. After the word flagged last_pixel the decoder restarts
// for a new image with the same settings; any register write also restarts
// it (palette contents are kept). Write registers only while idle.
// Throughput: one byte per cycle, sustained, as long as the pixels sink
// keeps ready high. From the last byte of a pixel to its output word the
// data passes the palette RAM read, then the color decode into the output register.
// The palette RAM is four byte lanes of PALETTE_DEPTH entries each.
module tga_rle_pixel_decoder import trd_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  trd_byte_if.sink    stream,
  trd_pixel_if.source pixels,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AddrW = $clog2(PALETTE_DEPTH);
  localparam int unsigned EntCap = (PALETTE_DEPTH > 511) ? 511 : PALETTE_DEPTH;

  // register indexes
  localparam logic [2:0] REG_KIND    = 3'd0;
  localparam logic [2:0] REG_RLE     = 3'd1;
  localparam logic [2:0] REG_PIXB    = 3'd2;
  localparam logic [2:0] REG_ENTB    = 3'd3;
  localparam logic [2:0] REG_FIRST   = 3'd4;
  localparam logic [2:0] REG_ENTRIES = 3'd5;
  localparam logic [2:0] REG_WIDTH   = 3'd6;
  localparam logic [2:0] REG_HEIGHT  = 3'd7;

  logic [1:0]  image_kind;
  logic        rle_enable;
  logic [2:0]  pixel_bytes;
  logic [2:0]  palette_entry_bytes;
  logic [7:0]  palette_first;
  logic [8:0]  palette_entries;
  logic [15:0] frame_width;
  logic [15:0] frame_height;
  logic [31:0] frame_total;   // width * height with zero taken as one

  cfg_t        cfg;
  logic [15:0] w_new, h_new, w_eff, h_eff;
  logic [31:0] total_next, restart_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_kind          <= KIND_TRUE;
      rle_enable          <= 1'b0;
      pixel_bytes         <= 3'd3;
      palette_entry_bytes <= 3'd3;
      palette_first       <= 8'd0;
      palette_entries     <= 9'd0;
      frame_width         <= 16'd1;
      frame_height        <= 16'd1;
      frame_total         <= 32'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KIND:    image_kind          <= cfg_data[1:0];
        REG_RLE:     rle_enable          <= cfg_data[0];
        REG_PIXB:    pixel_bytes         <= cfg_data[2:0];
        REG_ENTB:    palette_entry_bytes <= cfg_data[2:0];
        REG_FIRST:   palette_first       <= cfg_data[7:0];
        REG_ENTRIES: palette_entries     <= cfg_data[8:0];
        REG_WIDTH:   frame_width         <= cfg_data;
        REG_HEIGHT:  frame_height        <= cfg_data;
        default:     ;
      endcase
      frame_total <= total_next;
    end
  end

  // pixel total with the value being written, so a write reloads the count
  always_comb begin
    w_new = (cfg_index == REG_WIDTH) ? cfg_data : frame_width;
    h_new = (cfg_index == REG_HEIGHT) ? cfg_data : frame_height;
    w_eff = (w_new == 16'd0) ? 16'd1 : w_new;
    h_eff = (h_new == 16'd0) ? 16'd1 : h_new;
    total_next    = 32'(w_eff) * 32'(h_eff);
    restart_total = cfg_we ? total_next : frame_total;
  end

  // clamp out-of-range byte counts and the palette entry count
  always_comb begin
    cfg.kind  = image_kind;
    cfg.rle   = rle_enable;
    cfg.first = palette_first;
    if (pixel_bytes == 3'd0) begin
      cfg.pix_bytes = 3'd1;
    end else if (pixel_bytes > 3'd4) begin
      cfg.pix_bytes = 3'd4;
    end else begin
      cfg.pix_bytes = pixel_bytes;
    end
    if (palette_entry_bytes < 3'd2) begin
      cfg.entry_bytes = 3'd2;
    end else if (palette_entry_bytes > 3'd4) begin
      cfg.entry_bytes = 3'd4;
    end else begin
      cfg.entry_bytes = palette_entry_bytes;
    end
    if ({1'b0, palette_entries} > ENT_W'(EntCap)) begin
      cfg.entries = ENT_W'(EntCap);
    end else begin
      cfg.entries = {1'b0, palette_entries};
    end
  end

  pend_t             pend;
  logic              pend_valid, pend_take;
  logic [3:0]        lane_we;
  logic [AddrW-1:0]  waddr, raddr;
  logic [7:0]        wdata;
  logic              re;
  logic [31:0]       pal_data;

  trd_parser #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_parser (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .restart       (cfg_we),
    .restart_total (restart_total),
    .in_valid      (stream.valid),
    .in_data       (stream.data_byte),
    .in_ready      (stream.ready),
    .pend          (pend),
    .pend_valid    (pend_valid),
    .pend_take     (pend_take),
    .lane_we       (lane_we),
    .waddr         (waddr),
    .wdata         (wdata),
    .re            (re),
    .raddr         (raddr)
  );

  // one RAM per entry byte; lane i holds byte i of every palette entry
  for (genvar i = 0; i < 4; i++) begin : g_lane
    trd_ram #(.WIDTH(8), .DEPTH(PALETTE_DEPTH)) u_ram (
      .clk   (clk),
      .we    (lane_we[i]),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (pal_data[8*i +: 8])
    );
  end

  trd_out u_out (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pend       (pend),
    .pend_valid (pend_valid),
    .pend_take  (pend_take),
    .pal_data   (pal_data),
    .pixels     (pixels)
  );

endmodule

FILE: test/tb.sv
module tb;
  import trd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // register indexes on the config port
  localparam logic [2:0] REG_IMAGE_KIND    = 3'd0;
  localparam logic [2:0] REG_RLE_ENABLE    = 3'd1;
  localparam logic [2:0] REG_PIXEL_BYTES   = 3'd2;
  localparam logic [2:0] REG_ENTRY_BYTES   = 3'd3;
  localparam logic [2:0] REG_PAL_FIRST     = 3'd4;
  localparam logic [2:0] REG_PAL_ENTRIES   = 3'd5;
  localparam logic [2:0] REG_FRAME_WIDTH   = 3'd6;
  localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd7;

  // kind code outside the package list, decodes as true color
  localparam logic [1:0] KIND_ODD = 2'd3;

  localparam int unsigned PAL_DEPTH  = 256;
  localparam int unsigned QUIET_CYC  = 6;     // pipeline is two deep, a bit of margin
  localparam int unsigned HOLD_CYC   = 300;   // long sink stall in the pressure test

  // one decoded pixel word as it should leave the block
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] rep;
    logic       bad;
    logic       last;
  } pixel_word_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  trd_byte_if  byte_ch ();
  trd_pixel_if pix_ch ();

  tga_rle_pixel_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .stream    (byte_ch),
    .pixels    (pix_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ------------------------------------------------------------------
  // Shadow of the decoder: registers, palette bytes and stream state
  // ------------------------------------------------------------------
  logic [1:0]  reg_kind;
  logic        reg_rle;
  logic [2:0]  reg_pix;
  logic [2:0]  reg_entb;
  logic [7:0]  reg_first;
  logic [8:0]  reg_entries;
  logic [15:0] reg_width;
  logic [15:0] reg_height;

  logic [7:0]        pal_bytes [0:PAL_DEPTH*4-1];
  int unsigned       pal_loaded;
  int unsigned       asm_idx;
  logic [31:0]       asm_word;
  logic              pkt_run;
  int unsigned       pkt_left;    // 0 means a packet header comes next
  longint unsigned   px_left;

  pixel_word_t pending_pixels [$];

  int unsigned err_count;
  int unsigned sent_bytes;
  int unsigned words_seen;
  int unsigned images_done;
  int unsigned bad_words;
  int unsigned run_words;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned hold_req;
  int unsigned hold_left;

  // out of range byte counts are clamped, as the block does
  function automatic int unsigned pix_len();
    if (reg_pix == 3'd0) return 1;
    return (reg_pix > 3'd4) ? 4 : reg_pix;
  endfunction

  function automatic int unsigned entry_len();
    if (reg_entb < 3'd2) return 2;
    return (reg_entb > 3'd4) ? 4 : reg_entb;
  endfunction

  function automatic int unsigned entry_count();
    return (reg_entries > PAL_DEPTH) ? PAL_DEPTH : reg_entries;
  endfunction

  // zero width or height counts as one
  function automatic longint unsigned frame_pixels();
    longint unsigned w;
    longint unsigned h;
    w = (reg_width == 16'd0) ? 1 : reg_width;
    h = (reg_height == 16'd0) ? 1 : reg_height;
    return w * h;
  endfunction

  task automatic restart_image();
    pal_loaded = 0;
    asm_idx    = 0;
    asm_word   = '0;
    pkt_run    = 1'b0;
    pkt_left   = 0;
    px_left    = frame_pixels();
  endtask

  // little endian bytes -> RGBA; 2 bytes is 5-5-5 unscaled, 1 byte gives black
  function automatic pixel_word_t unpack_color(input logic [31:0] b, input int unsigned n);
    pixel_word_t p;
    p = '0;
    if (n == 2) begin
      p.red   = {3'b000, b[14:10]};
      p.green = {3'b000, b[9:5]};
      p.blue  = {3'b000, b[4:0]};
    end else if (n >= 3) begin
      p.red   = b[23:16];
      p.green = b[15:8];
      p.blue  = b[7:0];
      if (n == 4) p.alpha = b[31:24];
    end
    return p;
  endfunction

  function automatic pixel_word_t decode_color();
    pixel_word_t     p;
    longint unsigned idx;
    int unsigned     eb;
    int unsigned     base;
    logic [31:0]     e;
    p = '0;
    if (reg_kind == KIND_PALETTE) begin
      idx = asm_word + reg_first;
      eb  = entry_len();
      if (idx >= entry_count()) begin
        p.bad = 1'b1;
      end else begin
        base = 32'(idx * eb);
        e = '0;
        for (int i = 0; i < eb; i++) e[8*i +: 8] = pal_bytes[base + i];
        p = unpack_color(e, eb);
      end
    end else if (reg_kind == KIND_GREY) begin
      p.red = asm_word[7:0];
      if (pix_len() >= 2) p.green = asm_word[15:8];
    end else begin
      p = unpack_color(asm_word, pix_len());
    end
    return p;
  endfunction

  // advance the shadow by one accepted stream byte, queue a pixel word if one is due
  task automatic track_byte(input logic [7:0] b);
    pixel_word_t     p;
    int unsigned     pal_total;
    longint unsigned rep;
    pal_total = entry_count() * entry_len();
    if (pal_loaded < pal_total) begin
      pal_bytes[pal_loaded] = b;
      pal_loaded++;
      return;
    end
    if (reg_rle && pkt_left == 0) begin
      pkt_run  = b[7];
      pkt_left = b[6:0] + 1;
      return;
    end
    asm_word = asm_word | ({24'd0, b} << (8 * asm_idx));
    asm_idx  = (asm_idx + 1) % 4;
    if (asm_idx != pix_len() % 4) return;
    p = decode_color();
    asm_idx  = 0;
    asm_word = '0;
    rep = 1;
    if (reg_rle) begin
      if (pkt_run) begin
        rep = pkt_left;
        pkt_left = 0;
      end else begin
        pkt_left--;
      end
    end
    // a run never reaches past the end of the image
    if (rep > px_left) rep = px_left;
    px_left = px_left - rep;
    p.rep  = rep[7:0];
    p.last = (px_left == 0);
    pending_pixels.push_back(p);
    if (p.last) restart_image();
  endtask

  // ------------------------------------------------------------------
  // Clock, reset, timeout
  // ------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("TIMEOUT at %0t, %0d pixel words still due", $time, pending_pixels.size());
    $display("DONE: errors detected");
    $finish;
  end

  // ------------------------------------------------------------------
  // Pixel sink: random ready, or a long hold when the test asks for one
  // ------------------------------------------------------------------
  initial begin
    pix_ch.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pix_ch.ready <= 1'b0;
      end else begin
        pix_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // every accepted pixel word is checked against the oldest prediction
  always @(posedge clk) begin : check_words
    pixel_word_t want;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        err_count++;
        $display("%0t: unexpected word: expected none, got r%0d g%0d b%0d a%0d rep%0d bad%0d last%0d",
                 $time, pix_ch.chan_red, pix_ch.chan_green, pix_ch.chan_blue,
                 pix_ch.chan_alpha, pix_ch.repeat_count, pix_ch.bad_index, pix_ch.last_pixel);
      end else begin
        want = pending_pixels.pop_front();
        check_field("chan_red", want.red, pix_ch.chan_red);
        check_field("chan_green", want.green, pix_ch.chan_green);
        check_field("chan_blue", want.blue, pix_ch.chan_blue);
        check_field("chan_alpha", want.alpha, pix_ch.chan_alpha);
        check_field("repeat_count", want.rep, pix_ch.repeat_count);
        check_field("bad_index", {7'd0, want.bad}, {7'd0, pix_ch.bad_index});
        check_field("last_pixel", {7'd0, want.last}, {7'd0, pix_ch.last_pixel});
        words_seen++;
        if (want.last) images_done++;
        if (want.bad) bad_words++;
        if (want.rep > 8'd1) run_words++;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stream side. Every task is entered and left at a falling edge.
  // ------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    track_byte(b);
    sent_bytes++;
    @(negedge clk);
  endtask

  // stop offering and wait until every predicted word is out
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  // drained, and header or palette bytes have also left the pipeline
  task automatic wait_quiet();
    wait_drained();
    repeat (QUIET_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_IMAGE_KIND:   reg_kind    = value[1:0];
      REG_RLE_ENABLE:   reg_rle     = value[0];
      REG_PIXEL_BYTES:  reg_pix     = value[2:0];
      REG_ENTRY_BYTES:  reg_entb    = value[2:0];
      REG_PAL_FIRST:    reg_first   = value[7:0];
      REG_PAL_ENTRIES:  reg_entries = value[8:0];
      REG_FRAME_WIDTH:  reg_width   = value;
      REG_FRAME_HEIGHT: reg_height  = value;
      default: ;
    endcase
    // any write restarts the image, palette bytes stay
    restart_image();
    @(negedge clk);
  endtask

  task automatic set_config(input logic [1:0] kind, input logic rle, input logic [2:0] pix,
                            input logic [2:0] entb, input logic [7:0] first,
                            input logic [8:0] ents, input logic [15:0] w, input logic [15:0] h);
    wait_quiet();
    write_reg(REG_IMAGE_KIND, {14'd0, kind});
    write_reg(REG_RLE_ENABLE, {15'd0, rle});
    write_reg(REG_PIXEL_BYTES, {13'd0, pix});
    write_reg(REG_ENTRY_BYTES, {13'd0, entb});
    write_reg(REG_PAL_FIRST, {8'd0, first});
    write_reg(REG_PAL_ENTRIES, {7'd0, ents});
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  // one stored pixel: for palettes mostly an index that hits a loaded entry
  task automatic send_pixel();
    int unsigned pb;
    int unsigned ents;
    int unsigned idx;
    pb   = pix_len();
    ents = entry_count();
    if (reg_kind == KIND_PALETTE && $urandom_range(0, 7) != 0) begin
      idx = (ents > reg_first) ? $urandom_range(0, ents - reg_first - 1) : $urandom_range(0, 255);
      for (int k = 0; k < pb; k++) send_byte(8'(idx >> (8 * k)));
    end else begin
      repeat (pb) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // palette, then well formed pixel data; stops after max_pkts packets on big frames
  task automatic send_image(input int unsigned max_pkts);
    longint unsigned left;
    int unsigned     cnt;
    int unsigned     pk;
    logic            is_run;
    repeat (entry_count() * entry_len()) send_byte(8'($urandom_range(0, 255)));
    left = frame_pixels();
    pk = 0;
    while (left > 0 && pk < max_pkts) begin
      pk++;
      if (!reg_rle) begin
        send_pixel();
        left--;
      end else begin
        is_run = 1'($urandom_range(0, 1));
        if (is_run)
          cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
        else
          cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
        // now and then a raw packet spills into the next image
        if (!is_run && cnt > left && $urandom_range(0, 9) != 0) cnt = left;
        send_byte({is_run, 7'(cnt - 1)});
        if (is_run) send_pixel();
        else repeat (cnt) send_pixel();
        left = (cnt >= left) ? 0 : left - cnt;
      end
    end
  endtask

  task automatic random_config(output bit big_frame);
    logic [1:0]  kind;
    logic [2:0]  pix;
    logic [2:0]  entb;
    int unsigned r;
    int unsigned first;
    int unsigned w;
    int unsigned h;
    r = $urandom_range(0, 9);
    kind = (r < 3) ? KIND_PALETTE : (r < 6) ? KIND_TRUE : (r < 9) ? KIND_GREY : KIND_ODD;
    if ($urandom_range(0, 7) != 0) pix = 3'($urandom_range(1, 4));
    else pix = $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(5, 7));
    if (kind == KIND_PALETTE && $urandom_range(0, 2) != 0) pix = 3'd1;
    if ($urandom_range(0, 7) != 0) entb = 3'($urandom_range(2, 4));
    else entb = $urandom_range(0, 1) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(5, 7));
    first = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
    big_frame = ($urandom_range(0, 11) == 0);
    w = big_frame ? $urandom_range(100, 65535) : $urandom_range(0, 6);
    h = big_frame ? $urandom_range(1, 65535) : $urandom_range(0, 3);
    set_config(kind, 1'($urandom_range(0, 1)), pix, entb, 8'(first),
               9'($urandom_range(0, 24)), 16'(w), 16'(h));
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // short hand-picked streams, one per corner of the decode
  task automatic test_directed();
    // reset settings: 3-byte BGR, 1x1
    send_byte(8'h00); send_byte(8'hff); send_byte(8'h5a);
    // 5-5-5: all ones, then only the unused top bit
    set_config(KIND_TRUE, 1'b0, 3'd2, 3'd3, 8'd0, 9'd0, 16'd2, 16'd1);
    send_byte(8'hff); send_byte(8'h7f); send_byte(8'h00); send_byte(8'h80);
    // palette of two 15-bit entries (entry size 0 clamps to 2), first index 1:
    // a run of index 0 hits entry 1, a raw index 1 falls off the palette
    set_config(KIND_PALETTE, 1'b1, 3'd1, 3'd0, 8'd1, 9'd2, 16'd3, 16'd1);
    send_byte(8'haa); send_byte(8'h55); send_byte(8'hff); send_byte(8'h7f);
    send_byte(8'h81); send_byte(8'h00);
    send_byte(8'h00); send_byte(8'h01);
    // kind three as true color, pixel size 7 clamps to 4, zero frame size,
    // a 128 run clipped to the single pixel
    set_config(KIND_ODD, 1'b1, 3'd7, 3'd3, 8'd0, 9'd0, 16'd0, 16'd0);
    send_byte(8'hff);
    send_byte(8'h12); send_byte(8'h34); send_byte(8'h56); send_byte(8'hff);
    // one-byte true color (size 0 acts as 1) decodes to black
    set_config(KIND_TRUE, 1'b0, 3'd0, 3'd3, 8'd0, 9'd0, 16'd1, 16'd1);
    send_byte(8'hff);
    // raw packet of two in a 1x1 image: the second byte opens the next image
    set_config(KIND_GREY, 1'b1, 3'd1, 3'd3, 8'd0, 9'd0, 16'd1, 16'd1);
    send_byte(8'h01); send_byte(8'hc3); send_byte(8'h3c);
  endtask

  // random settings per phase, mostly well formed images, some plain noise
  task automatic test_random_streams(input int unsigned budget);
    int unsigned start;
    bit          big_frame;
    start = sent_bytes;
    while (sent_bytes - start < budget) begin
      random_config(big_frame);
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(5, 30)) send_byte(8'($urandom_range(0, 255)));
      else if (big_frame)
        send_image(30);
      else
        repeat ($urandom_range(1, 3)) send_image(40);
    end
  endtask

  // register maxima: full palette with entry 255 as the only good index,
  // and largest frames with 4-byte pixels in RLE packets
  task automatic test_register_extremes();
    set_config(KIND_PALETTE, 1'b1, 3'd1, 3'd0, 8'd255, 9'd511, 16'hffff, 16'hffff);
    send_image(8);
    set_config(KIND_TRUE, 1'b1, 3'd4, 3'd7, 8'd0, 9'd0, 16'hffff, 16'hffff);
    send_image(5);
  endtask

  // sink stalls long enough to back up the block into the stream side;
  // halfway the sender waits for everything to drain
  task automatic test_backpressure();
    set_config(KIND_GREY, 1'b0, 3'd1, 3'd3, 8'd0, 9'd0, 16'd40, 16'd5);
    @(posedge clk);
    hold_req = HOLD_CYC;
    @(negedge clk);
    for (int k = 0; k < 60; k++) begin
      send_byte(8'($urandom_range(0, 255)));
      if (k == 29) wait_drained();
    end
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    hold_req          = 0;
    err_count         = 0;
    sent_bytes        = 0;
    words_seen        = 0;
    images_done       = 0;
    bad_words         = 0;
    run_words         = 0;
    src_idle_pct      = 34;
    snk_idle_pct      = 55;

    // reset values of the registers
    reg_kind    = KIND_TRUE;
    reg_rle     = 1'b0;
    reg_pix     = 3'd3;
    reg_entb    = 3'd3;
    reg_first   = 8'd0;
    reg_entries = 9'd0;
    reg_width   = 16'd1;
    reg_height  = 16'd1;
    for (int i = 0; i < PAL_DEPTH * 4; i++) pal_bytes[i] = 8'd0;
    restart_image();

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_streams(40);

    src_idle_pct = 55;
    snk_idle_pct = 34;
    test_random_streams(40);

    // no idling from here on
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_register_extremes();
    test_random_streams(40);
    test_backpressure();

    wait_quiet();
    repeat (20) @(negedge clk);

    $display("Summary: %0d stream bytes in, %0d pixel words checked, %0d images finished",
             sent_bytes, words_seen, images_done);
    $display("Summary: palette, true color, 5-5-5 and grey, raw and RLE, %0d runs, %0d bad indexes",
             run_words, bad_words);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/trd_pkg.sv
hw/rtl/trd_byte_if.sv
hw/rtl/trd_pixel_if.sv
hw/rtl/trd_ram.sv
hw/rtl/trd_parser.sv
hw/rtl/trd_out.sv
hw/rtl/tga_rle_pixel_decoder.sv
test/tb.sv
